// ===== sv/mersenne_twister_generator_assert.svh =====
// ----------------------------------------------------------------------------
// MT19937 generator assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MERSENNE_TWISTER_GENERATOR_ASSERT_SVH
`define MERSENNE_TWISTER_GENERATOR_ASSERT_SVH

// Same-cycle implication.
`define MTG_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define MTG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/mtg_pkg.sv =====
// ----------------------------------------------------------------------------
// MT19937 generator package
// Constants and word functions shared by the generator and its state RAM.
// ----------------------------------------------------------------------------
package mtg_pkg;

   localparam int WORD_W             = 32;
   localparam int STATE_WORDS_DEF    = 624;
   localparam int SHIFT_DISTANCE_DEF = 397;

   localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
   localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd5489;
   localparam logic [WORD_W-1:0] UPPER_MASK   = 32'h8000_0000;
   localparam logic [WORD_W-1:0] LOWER_MASK   = 32'h7fff_ffff;
   localparam logic [WORD_W-1:0] TWIST_XOR    = 32'h9908_b0df;
   localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
   localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;

   localparam int SEED_SHIFT = 30;
   localparam int TEMPER_U   = 11;
   localparam int TEMPER_S   = 7;
   localparam int TEMPER_T   = 15;
   localparam int TEMPER_L   = 18;

   // Fold one word before the seeding multiply.
   function automatic logic [WORD_W-1:0] seed_fold(input logic [WORD_W-1:0] p);
      return p ^ (p >> SEED_SHIFT);
   endfunction

   // One twist step: upper bit of a, lower bits of b, xor into the tap word c.
   function automatic logic [WORD_W-1:0] twist_mix(input logic [WORD_W-1:0] a,
                                                   input logic [WORD_W-1:0] b,
                                                   input logic [WORD_W-1:0] c);
      logic [WORD_W-1:0] y;
      y = (a & UPPER_MASK) | (b & LOWER_MASK);
      return c ^ (y >> 1) ^ (y[0] ? TWIST_XOR : '0);
   endfunction

   function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] x);
      logic [WORD_W-1:0] y;
      y = x;
      y = y ^ (y >> TEMPER_U);
      y = y ^ ((y << TEMPER_S) & TEMPER_B);
      y = y ^ ((y << TEMPER_T) & TEMPER_C);
      y = y ^ (y >> TEMPER_L);
      return y;
   endfunction

endpackage

// ===== sv/mtg_ram.sv =====
// ----------------------------------------------------------------------------
// MT19937 generator state RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mtg_ram
   import mtg_pkg::*;
#(
   parameter int WIDTH = WORD_W,
   parameter int DEPTH = STATE_WORDS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // hold read data when not enabled
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== sv/mersenne_twister_generator.sv =====
// ----------------------------------------------------------------------------
// MT19937 generator, 32-bit
// Draw and reseed transactions against a 624-word state held in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: req_tuser[0] is the opcode (0 = draw, 1 = reseed), req_tdata
//   carries the 32-bit seed, read only on a reseed. rsp channel: one tempered
//   32-bit word per draw; a reseed returns nothing.
//   The block takes one transaction at a time; req_tready is high only while
//   the sequencer is idle.
//   Draw from a filled state: a RAM read, a wait for the registered data, then
//   the tempered word is loaded; the next request is taken the cycle after.
//   Draw at the end of the state: a twist pass first (one RAM read pair and
//   one write per word, one shared mixing unit).
//   Reseed: the multiply-then-add chain of the seeding recurrence, one
//   registered 32x32 multiply per word.
//   Reset: the state RAM is not cleared; the read position marks the state as
//   never seeded, so the first draw seeds with 5489, twists, then reads.
//   Receiver stall: a finished word waits in the output register; a reseed may
//   be taken meanwhile, a following draw waits before loading its result.
// ----------------------------------------------------------------------------
`include "mersenne_twister_generator_assert.svh"

module mersenne_twister_generator
   import mtg_pkg::*;
#(
   parameter int STATE_WORDS    = STATE_WORDS_DEF,
   parameter int SHIFT_DISTANCE = SHIFT_DISTANCE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [WORD_W-1:0] req_tdata,   // [31:0] seed_value
   input  logic [0:0]        req_tuser,   // [0] opcode
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [WORD_W-1:0] rsp_tdata    // [31:0] random_word
);

   localparam int ADDR_W    = $clog2(STATE_WORDS);
   localparam int POS_W     = $clog2(STATE_WORDS + 2);
   localparam int TAP_SPLIT = STATE_WORDS - SHIFT_DISTANCE;

   localparam logic [POS_W-1:0]  POS_END      = POS_W'(STATE_WORDS);
   localparam logic [POS_W-1:0]  POS_UNSEEDED = POS_W'(STATE_WORDS + 1);
   localparam logic [ADDR_W-1:0] ADDR_LAST    = ADDR_W'(STATE_WORDS - 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED_FIRST,
      ST_SEED_MUL,
      ST_SEED_ADD,
      ST_TW_PRIME,
      ST_TW_ISSUE,
      ST_TW_WRITE,
      ST_DRAW_READ,
      ST_DRAW_WAIT
   } state_type;

   state_type          state_ff;
   logic [POS_W-1:0]   pos_ff;
   logic [ADDR_W-1:0]  idx_ff;         // seed word index / twist word index
   logic               draw_pending_ff;
   logic [WORD_W-1:0]  prev_ff;        // previous seed word
   logic [WORD_W-1:0]  prod_ff;        // registered seeding product
   logic [WORD_W-1:0]  cur_ff;         // unmodified word at the twist index
   logic               rsp_tvalid_ff;
   logic [WORD_W-1:0]  rsp_tdata_ff;

   logic [WORD_W-1:0]  prod_in;
   logic [WORD_W-1:0]  seed_word_in;
   logic [WORD_W-1:0]  twist_word_in;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [WORD_W-1:0]  wr_data;
   logic               rd_a_en;
   logic [ADDR_W-1:0]  rd_a_addr;
   logic [WORD_W-1:0]  rd_a_data;
   logic               rd_b_en;
   logic [ADDR_W-1:0]  rd_b_addr;
   logic [WORD_W-1:0]  rd_b_data;

   logic [ADDR_W-1:0]  next_addr;
   logic [ADDR_W-1:0]  tap_addr;
   logic               req_accept;
   logic               rsp_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Neighbor and tap addresses of the twist step; both wrap around the state.
   assign next_addr = (idx_ff == ADDR_LAST) ? '0 : idx_ff + 1'b1;
   assign tap_addr  = (idx_ff < ADDR_W'(TAP_SPLIT)) ?
                      idx_ff + ADDR_W'(SHIFT_DISTANCE) :
                      idx_ff - ADDR_W'(TAP_SPLIT);

   assign prod_in       = SEED_MULT * seed_fold(prev_ff);
   assign seed_word_in  = prod_ff + WORD_W'(idx_ff);
   // rd_a holds the old neighbor word, rd_b the tap word (already new past the split).
   assign twist_word_in = twist_mix(cur_ff, rd_a_data, rd_b_data);

   // RAM port steering per sequencer state.
   always_comb begin
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_data   = twist_word_in;
      rd_a_en   = 1'b0;
      rd_a_addr = next_addr;
      rd_b_en   = 1'b0;
      rd_b_addr = tap_addr;
      case (state_ff)
         ST_SEED_FIRST: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = prev_ff;
         end
         ST_SEED_ADD: begin
            wr_en   = 1'b1;
            wr_data = seed_word_in;
         end
         ST_TW_PRIME: begin
            rd_a_en   = 1'b1;
            rd_a_addr = '0;
         end
         ST_TW_ISSUE: begin
            rd_a_en = 1'b1;
            rd_b_en = 1'b1;
         end
         ST_TW_WRITE: begin
            wr_en = 1'b1;
         end
         ST_DRAW_READ: begin
            rd_a_en   = 1'b1;
            rd_a_addr = pos_ff[ADDR_W-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         pos_ff          <= POS_UNSEEDED;
         idx_ff          <= '0;
         draw_pending_ff <= 1'b0;
         rsp_tvalid_ff   <= 1'b0;
      end else begin
         // Load a finished word, or drop the valid flag once it is taken.
         if (state_ff == ST_DRAW_WAIT && rsp_free) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  if (req_tuser[0]) begin
                     // reseed: drop any pending draw, restart the stream
                     prev_ff         <= req_tdata;
                     draw_pending_ff <= 1'b0;
                     state_ff        <= ST_SEED_FIRST;
                  end else if (pos_ff == POS_UNSEEDED) begin
                     prev_ff         <= DEFAULT_SEED;
                     draw_pending_ff <= 1'b1;
                     state_ff        <= ST_SEED_FIRST;
                  end else if (pos_ff == POS_END) begin
                     state_ff <= ST_TW_PRIME;
                  end else begin
                     state_ff <= ST_DRAW_READ;
                  end
               end
            end
            ST_SEED_FIRST: begin
               idx_ff   <= ADDR_W'(1);
               state_ff <= ST_SEED_MUL;
            end
            ST_SEED_MUL: begin
               prod_ff  <= prod_in;
               state_ff <= ST_SEED_ADD;
            end
            ST_SEED_ADD: begin
               prev_ff <= seed_word_in;
               if (idx_ff == ADDR_LAST) begin
                  pos_ff          <= POS_END;
                  draw_pending_ff <= 1'b0;
                  state_ff        <= draw_pending_ff ? ST_TW_PRIME : ST_IDLE;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= ST_SEED_MUL;
               end
            end
            ST_TW_PRIME: begin
               idx_ff   <= '0;
               state_ff <= ST_TW_ISSUE;
            end
            ST_TW_ISSUE: begin
               // first step takes word 0 from the priming read
               if (idx_ff == '0) begin
                  cur_ff <= rd_a_data;
               end
               state_ff <= ST_TW_WRITE;
            end
            ST_TW_WRITE: begin
               // the neighbor read now is the next step's unmodified word
               cur_ff <= rd_a_data;
               if (idx_ff == ADDR_LAST) begin
                  pos_ff   <= '0;
                  state_ff <= ST_DRAW_READ;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= ST_TW_ISSUE;
               end
            end
            ST_DRAW_READ: begin
               pos_ff   <= pos_ff + 1'b1;
               state_ff <= ST_DRAW_WAIT;
            end
            ST_DRAW_WAIT: begin
               // hold the read word until the output register frees up
               if (rsp_free) begin
                  rsp_tdata_ff <= temper(rd_a_data);
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   mtg_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STATE_WORDS)
   ) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_a_en),
      .rd_addr (rd_a_addr),
      .rd_data (rd_a_data)
   );

   // Second copy, written in lockstep, supplies the tap read of the twist.
   mtg_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STATE_WORDS)
   ) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_b_en),
      .rd_addr (rd_b_addr),
      .rd_data (rd_b_data)
   );

   `MTG_ASSERT_NOW(a_pos_range, 1'b1, pos_ff <= POS_UNSEEDED, "read position out of range")
   `MTG_ASSERT_NOW(a_draw_seeded, state_ff == ST_DRAW_READ, pos_ff < POS_END, "draw from unfilled state")
   `MTG_ASSERT_NOW(a_wr_addr, wr_en, wr_addr <= ADDR_LAST, "state write beyond last word")
   `MTG_ASSERT_NEXT(a_rsp_load, state_ff == ST_DRAW_WAIT && rsp_free, rsp_tvalid_ff && state_ff == ST_IDLE, "draw result not loaded")

endmodule

// ===== sim/mt_stream_checker.sv =====
// ----------------------------------------------------------------------------
// MT19937 stream checker
// Watches the request and result channels, keeps its own copy of the 624-word
// state, predicts the tempered word of every accepted draw and compares it
// with the next accepted result.
// ----------------------------------------------------------------------------
module mt_stream_checker
   import mtg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [WORD_W-1:0] req_tdata,   // [31:0] seed_value
   input  logic [0:0]        req_tuser,   // [0] opcode
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [WORD_W-1:0] rsp_tdata,   // [31:0] random_word
   output int                mismatch_total,
   output int                words_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int   N            = STATE_WORDS_DEF;
   localparam int   M            = SHIFT_DISTANCE_DEF;
   localparam logic OP_RESEED    = 1'b1;
   localparam int   REPORT_LIMIT = 10;

   logic [WORD_W-1:0] mt_words [N];
   logic [9:0]        read_pos;
   logic [WORD_W-1:0] expected_words [$];

   // Fill the state by the seeding recurrence and restart the stream.
   function automatic void seed_state(input logic [WORD_W-1:0] s);
      logic [WORD_W-1:0] p;
      mt_words[0] = s;
      for (int i = 1; i < N; i++) begin
         p = mt_words[i-1];
         mt_words[i] = SEED_MULT * (p ^ (p >> SEED_SHIFT)) + WORD_W'(i);
      end
      read_pos = 10'(N);
   endfunction

   function automatic void log_failure(input string what);
      if (mismatch_total < REPORT_LIMIT) begin
         $display("%0t ns: random_word check failed: %s", $time, what);
      end
      mismatch_total++;
   endfunction

   always @(posedge clock) begin : watch
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] want;
      if (reset) begin
         read_pos = 10'(N + 1);
         expected_words.delete();
         mismatch_total = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               log_failure($sformatf("got %h with no draw pending", rsp_tdata));
            end else begin
               want = expected_words.pop_front();
               if (rsp_tdata !== want) begin
                  log_failure($sformatf("expected %h, got %h", want, rsp_tdata));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser[0] == OP_RESEED) begin
               seed_state(req_tdata);
            end else begin
               // Twist the whole store once the position has run off the end.
               if (read_pos >= 10'(N)) begin
                  if (read_pos == 10'(N + 1)) begin
                     seed_state(DEFAULT_SEED);
                  end
                  for (int k = 0; k < N; k++) begin
                     y = (mt_words[k] & UPPER_MASK) | (mt_words[(k + 1) % N] & LOWER_MASK);
                     mt_words[k] = mt_words[(k + M) % N] ^ (y >> 1)
                                   ^ (y[0] ? TWIST_XOR : '0);
                  end
                  read_pos = '0;
               end
               y = mt_words[read_pos];
               read_pos = read_pos + 1'b1;
               y = y ^ (y >> TEMPER_U);
               y = y ^ ((y << TEMPER_S) & TEMPER_B);
               y = y ^ ((y << TEMPER_T) & TEMPER_C);
               y = y ^ (y >> TEMPER_L);
               expected_words.push_back(y);
            end
         end
      end
      words_outstanding = expected_words.size();
   end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// MT19937 generator testbench
// Drives draw and reseed transactions with random sender gaps and receiver
// stalls, lets the stream checker predict and compare every word, and gives
// the verdict once no draw is pending.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mtg_pkg::*;

   localparam logic OP_DRAW   = 1'b0;
   localparam logic OP_RESEED = 1'b1;

   // Length of the long draw run: enough to exhaust the state and twist again.
   localparam int LONG_RUN    = STATE_WORDS_DEF + 2;
   localparam int SEGMENT_ITEMS = 40;
   // Long enough for a reseed or a twist pass, plus some slack.
   localparam int DRAIN_CYCLES = 2 * STATE_WORDS_DEF + 16;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [WORD_W-1:0] req_tdata;   // [31:0] seed_value
   logic [0:0]        req_tuser;   // [0] opcode
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [WORD_W-1:0] rsp_tdata;   // [31:0] random_word

   int                mismatch_total;
   int                words_outstanding;

   // Set for stretches where neither side idles.
   bit                steady_flow;

   mersenne_twister_generator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   mt_stream_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .req_tuser         (req_tuser),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .mismatch_total    (mismatch_total),
      .words_outstanding (words_outstanding)
   );

   always begin
      clock = 1'b0;
      #5ns;
      clock = 1'b1;
      #5ns;
   end

   // Stop a hung run. Worst case is every item paying a full reseed or twist
   // pass plus the longest gap and stall; this leaves several times that.
   initial begin
      #50ms;
      $display("Test completed with failures");
      $finish;
   end

   // Pick a seed, leaning on the extremes and the default seed.
   function automatic logic [WORD_W-1:0] pick_seed();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return DEFAULT_SEED;
         default: return $urandom;
      endcase
   endfunction

   // Offer one transaction and hold it until accepted. Enter and leave at a
   // falling edge; valid stays high on exit so back-to-back items never drop it.
   task automatic push_item(input logic op, input logic [WORD_W-1:0] seed);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= seed;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Receiver: stall a random number of cycles, then take one word.
   initial begin : receiver
      int stall;
      rsp_tready = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, 10);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int issued;
      int run_len;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = OP_DRAW;
      steady_flow = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. Draw before any reseed: the block seeds with 5489 first.
      push_item(OP_DRAW,   '0);
      // Seed field is ignored on a draw.
      push_item(OP_DRAW,   '1);
      push_item(OP_DRAW,   32'h5555_aaaa);
      push_item(OP_RESEED, '0);
      push_item(OP_DRAW,   '0);
      push_item(OP_DRAW,   '1);
      push_item(OP_RESEED, '1);
      push_item(OP_DRAW,   32'haaaa_5555);
      // Reseed with the default seed: the stream restarts from its first word.
      push_item(OP_RESEED, DEFAULT_SEED);
      push_item(OP_DRAW,   '0);
      push_item(OP_DRAW,   '0);
      // Back-to-back reseeds: only the last one counts.
      push_item(OP_RESEED, 32'h0000_04d2);
      push_item(OP_RESEED, 32'h8000_0001);
      push_item(OP_DRAW,   '1);
      steady_flow = 1'b1;
      push_item(OP_RESEED, 32'h7fff_fffe);
      push_item(OP_DRAW,   '0);
      push_item(OP_DRAW,   '1);
      push_item(OP_RESEED, 32'ha5a5_a5a5);
      push_item(OP_DRAW,   '0);
      steady_flow = 1'b0;

      // Long draw run: use up the whole state and force a second twist pass.
      push_item(OP_RESEED, pick_seed());
      for (int i = 0; i < LONG_RUN; i++) begin
         if (i % 50 == 0) begin
            steady_flow = ($urandom_range(0, 2) == 0);
         end
         push_item(OP_DRAW, $urandom);
      end

      // Random segments: mostly reseed-then-draw runs, some plain draw runs,
      // and some noise of lone or back-to-back reseeds.
      issued = 0;
      while (issued < SEGMENT_ITEMS) begin
         steady_flow = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 7))
            0: begin
               run_len = $urandom_range(1, 3);
               repeat (run_len) push_item(OP_RESEED, pick_seed());
               issued += run_len;
            end
            1, 2: begin
               run_len = $urandom_range(1, 30);
               repeat (run_len) push_item(OP_DRAW, $urandom);
               issued += run_len;
            end
            default: begin
               run_len = $urandom_range(1, 30);
               push_item(OP_RESEED, pick_seed());
               repeat (run_len) push_item(OP_DRAW, $urandom);
               issued += run_len + 1;
            end
         endcase
      end
      steady_flow = 1'b0;
      req_tvalid <= 1'b0;

      // Drain: wait for every pending word, then let a trailing reseed finish.
      while (words_outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_total == 0 && words_outstanding == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/mtg_pkg.sv
sv/mtg_ram.sv
sv/mersenne_twister_generator.sv
sim/mt_stream_checker.sv
sim/tb.sv
